@@ hw/rtl/vcdg_pkg.sv @@
// Shared types, constants and helpers for the voxel gradient block.
`default_nettype none

package vcdg_pkg;

   localparam int COORD_W   = 5;
   localparam int CHAN_W    = 16;
   localparam int GRAD_W    = 17;
   localparam int SIZE_W    = 6;
   localparam int PLANE_W   = 2 * SIZE_W;
   localparam int YSX_W     = COORD_W + SIZE_W;
   localparam int ZPL_W     = COORD_W + PLANE_W;
   localparam int BASE_W    = ZPL_W + 1;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   // Neighbor slots in the in-volume flag vector
   localparam int NB_XM = 0;
   localparam int NB_XP = 1;
   localparam int NB_YM = 2;
   localparam int NB_YP = 3;
   localparam int NB_ZM = 4;
   localparam int NB_ZP = 5;
   localparam int NB_N  = 6;

   typedef struct packed {
      logic [SIZE_W-1:0]  size_x;
      logic [SIZE_W-1:0]  size_y;
      logic [SIZE_W-1:0]  size_z;
      logic [PLANE_W-1:0] plane;
   } geom_type;

   typedef struct packed {
      logic signed [CHAN_W-1:0] red;
      logic signed [CHAN_W-1:0] green;
      logic signed [CHAN_W-1:0] blue;
   } voxel_type;

   typedef struct packed {
      logic              is_query;
      logic              wr_ok;
      logic [NB_N-1:0]   nb_ok;
      logic [BASE_W-1:0] base;
      voxel_type         color;
   } cmd_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] grad_x;
      logic signed [GRAD_W-1:0] grad_y;
      logic signed [GRAD_W-1:0] grad_z;
   } rsp_type;

   // Difference of two channel values; a neighbor outside the volume counts as zero.
   function automatic logic signed [GRAD_W-1:0] chan_diff(
      input logic signed [CHAN_W-1:0] a,
      input logic                     a_ok,
      input logic signed [CHAN_W-1:0] b,
      input logic                     b_ok
   );
      logic signed [GRAD_W-1:0] av;
      logic signed [GRAD_W-1:0] bv;
      av = a_ok ? GRAD_W'(a) : '0;
      bv = b_ok ? GRAD_W'(b) : '0;
      return av - bv;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vcdg_fifo.sv @@
// Small register queue used between the block's parts and on the result side.
`default_nettype none

module vcdg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/vcdg_csr.sv @@
// Volume size registers with clamping and the registered plane size.
`default_nettype none

module vcdg_csr
   import vcdg_pkg::*;
#(
   parameter int MAX_SIDE = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata,
   output geom_type             geom
);

   localparam logic [8:0]         SIDE_LIM  = 9'(MAX_SIDE);
   localparam logic [SIZE_W-1:0]  SIZE_RST  = (MAX_SIDE < 32) ? SIZE_W'(MAX_SIDE) : SIZE_W'(32);
   localparam logic [PLANE_W-1:0] PLANE_RST = PLANE_W'(SIZE_RST) * PLANE_W'(SIZE_RST);

   logic [SIZE_W-1:0]  size_x_ff, size_x_in;
   logic [SIZE_W-1:0]  size_y_ff, size_y_in;
   logic [SIZE_W-1:0]  size_z_ff, size_z_in;
   logic [PLANE_W-1:0] plane_ff, plane_in;
   logic [SIZE_W-1:0]  eff_size;

   // Zero acts as one, anything past the largest side acts as the largest side.
   always_comb begin
      priority if (csr_wdata == '0) begin
         eff_size = SIZE_W'(1);
      end else if ({3'b000, csr_wdata} > SIDE_LIM) begin
         eff_size = SIZE_W'(MAX_SIDE);
      end else begin
         eff_size = csr_wdata;
      end
   end

   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SIZE_X: size_x_in = eff_size;
            CSR_SIZE_Y: size_y_in = eff_size;
            CSR_SIZE_Z: size_z_in = eff_size;
            default:    ;
         endcase
      end
      plane_in = PLANE_W'(size_x_ff) * PLANE_W'(size_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RST;
         size_y_ff <= SIZE_RST;
         size_z_ff <= SIZE_RST;
         plane_ff  <= PLANE_RST;
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         size_z_ff <= size_z_in;
         plane_ff  <= plane_in;
      end
   end

   assign geom = '{size_x: size_x_ff, size_y: size_y_ff, size_z: size_z_ff, plane: plane_ff};

endmodule

`default_nettype wire

@@ hw/rtl/vcdg_front.sv @@
// Front part: accepts items, classifies neighbors and forms the linear voxel address.
`default_nettype none

module vcdg_front
   import vcdg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic                     req_mode,
   input  logic [COORD_W-1:0]       req_coord_x,
   input  logic [COORD_W-1:0]       req_coord_y,
   input  logic [COORD_W-1:0]       req_coord_z,
   input  logic signed [CHAN_W-1:0] req_red_in,
   input  logic signed [CHAN_W-1:0] req_green_in,
   input  logic signed [CHAN_W-1:0] req_blue_in,
   input  geom_type                 geom,
   output logic                     cmd_push,
   output cmd_type                  cmd_data,
   input  logic                     cmd_full
);

   // Stage A: accepted item
   logic                  a_valid_ff, a_valid_in;
   logic                  a_mode_ff;
   logic [COORD_W-1:0]    a_x_ff, a_y_ff, a_z_ff;
   voxel_type             a_color_ff;

   // Stage B: flags and partial products
   logic                  b_valid_ff, b_valid_in;
   logic                  b_query_ff;
   logic                  b_wr_ok_ff;
   logic [NB_N-1:0]       b_nb_ok_ff;
   logic [COORD_W-1:0]    b_x_ff;
   logic [YSX_W-1:0]      b_ysx_ff;
   logic [ZPL_W-1:0]      b_zpl_ff;
   voxel_type             b_color_ff;

   logic                  accept, a_move, b_free;
   logic [SIZE_W-1:0]     ax, ay, az;
   logic                  x_in, y_in, z_in;
   logic [NB_N-1:0]       nb_ok;

   assign b_free   = !b_valid_ff || !cmd_full;
   assign a_move   = a_valid_ff && b_free;
   assign req_full = a_valid_ff && !b_free;
   assign accept   = req_push && !req_full;
   assign cmd_push = b_valid_ff && !cmd_full;

   always_comb begin
      a_valid_in = accept || (a_valid_ff && !a_move);
      b_valid_in = a_move || (b_valid_ff && !cmd_push);
   end

   // Classify each neighbor as inside or outside the configured volume.
   always_comb begin
      ax   = {1'b0, a_x_ff};
      ay   = {1'b0, a_y_ff};
      az   = {1'b0, a_z_ff};
      x_in = ax < geom.size_x;
      y_in = ay < geom.size_y;
      z_in = az < geom.size_z;
      nb_ok[NB_XM] = (a_x_ff != '0) && (ax <= geom.size_x) && y_in && z_in;
      nb_ok[NB_XP] = ((ax + SIZE_W'(1)) < geom.size_x) && y_in && z_in;
      nb_ok[NB_YM] = (a_y_ff != '0) && (ay <= geom.size_y) && x_in && z_in;
      nb_ok[NB_YP] = ((ay + SIZE_W'(1)) < geom.size_y) && x_in && z_in;
      nb_ok[NB_ZM] = (a_z_ff != '0) && (az <= geom.size_z) && x_in && y_in;
      nb_ok[NB_ZP] = ((az + SIZE_W'(1)) < geom.size_z) && x_in && y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_mode_ff  <= req_mode;
         a_x_ff     <= req_coord_x;
         a_y_ff     <= req_coord_y;
         a_z_ff     <= req_coord_z;
         a_color_ff <= '{red: req_red_in, green: req_green_in, blue: req_blue_in};
      end
      if (a_move) begin
         b_query_ff <= a_mode_ff;
         b_wr_ok_ff <= x_in && y_in && z_in;
         b_nb_ok_ff <= nb_ok;
         b_x_ff     <= a_x_ff;
         b_ysx_ff   <= YSX_W'(a_y_ff) * YSX_W'(geom.size_x);
         b_zpl_ff   <= ZPL_W'(a_z_ff) * ZPL_W'(geom.plane);
         b_color_ff <= a_color_ff;
      end
   end

   always_comb begin
      cmd_data.is_query = b_query_ff;
      cmd_data.wr_ok    = b_wr_ok_ff;
      cmd_data.nb_ok    = b_nb_ok_ff;
      cmd_data.base     = BASE_W'(b_x_ff) + BASE_W'(b_ysx_ff) + BASE_W'(b_zpl_ff);
      cmd_data.color    = b_color_ff;
   end

endmodule

`default_nettype wire

@@ hw/rtl/vcdg_back.sv @@
// Back part: voxel memory, write execution and the three-step neighbor read sequencer.
`default_nettype none

module vcdg_back
   import vcdg_pkg::*;
#(
   parameter int MAX_SIDE = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  geom_type geom,
   input  logic     cmd_empty,
   output logic     cmd_pop,
   input  cmd_type  cmd_data,
   input  logic     rsp_full,
   output logic     rsp_push,
   output rsp_type  rsp_data
);

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic [1:0] ST_X = 2'd0;
   localparam logic [1:0] ST_Y = 2'd1;
   localparam logic [1:0] ST_Z = 2'd2;

   voxel_type mem [DEPTH];

   logic [1:0]               state_ff, state_in;
   logic                     res_pend_ff, res_pend_in;
   cmd_type                  cur_ff, cur_in;
   logic signed [GRAD_W-1:0] gx_ff, gx_in;
   logic signed [GRAD_W-1:0] gy_ff, gy_in;
   logic signed [GRAD_W-1:0] gz;
   voxel_type                rd_a_ff, rd_b_ff;
   logic                     rd_en, wr_en;
   logic [ADDR_W-1:0]        rd_addr_a, rd_addr_b, wr_addr;

   always_comb begin
      state_in    = state_ff;
      res_pend_in = res_pend_ff;
      cur_in      = cur_ff;
      gx_in       = gx_ff;
      gy_in       = gy_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      rd_addr_a   = '0;
      rd_addr_b   = '0;
      wr_addr     = ADDR_W'(cmd_data.base);
      gz          = chan_diff(rd_a_ff.blue, cur_ff.nb_ok[NB_ZM],
                              rd_b_ff.blue, cur_ff.nb_ok[NB_ZP]);
      unique case (state_ff)
         ST_X: begin
            // Drain the finished query, then take the next command.
            if (res_pend_ff && !rsp_full) begin
               rsp_push    = 1'b1;
               res_pend_in = 1'b0;
            end
            if (!cmd_empty && (!res_pend_ff || !rsp_full)) begin
               cmd_pop = 1'b1;
               cur_in  = cmd_data;
               if (cmd_data.is_query) begin
                  rd_en     = 1'b1;
                  rd_addr_a = ADDR_W'(cmd_data.base - BASE_W'(1));
                  rd_addr_b = ADDR_W'(cmd_data.base + BASE_W'(1));
                  state_in  = ST_Y;
               end else begin
                  wr_en = cmd_data.wr_ok;
               end
            end
         end
         ST_Y: begin
            rd_en     = 1'b1;
            rd_addr_a = ADDR_W'(cur_ff.base - BASE_W'(geom.size_x));
            rd_addr_b = ADDR_W'(cur_ff.base + BASE_W'(geom.size_x));
            gx_in     = chan_diff(rd_a_ff.red, cur_ff.nb_ok[NB_XM],
                                  rd_b_ff.red, cur_ff.nb_ok[NB_XP]);
            state_in  = ST_Z;
         end
         ST_Z: begin
            rd_en       = 1'b1;
            rd_addr_a   = ADDR_W'(cur_ff.base - BASE_W'(geom.plane));
            rd_addr_b   = ADDR_W'(cur_ff.base + BASE_W'(geom.plane));
            gy_in       = chan_diff(rd_a_ff.green, cur_ff.nb_ok[NB_YM],
                                    rd_b_ff.green, cur_ff.nb_ok[NB_YP]);
            res_pend_in = 1'b1;
            state_in    = ST_X;
         end
         default: begin
            state_in = ST_X;
         end
      endcase
   end

   assign rsp_data = '{grad_x: gx_ff, grad_y: gy_ff, grad_z: gz};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_X;
         res_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         res_pend_ff <= res_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      gx_ff  <= gx_in;
      gy_ff  <= gy_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= cmd_data.color;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/voxel_central_difference_gradient.sv @@
// Top level of the voxel central-difference gradient block.
//
// The block keeps a volume of up to MAX_SIDE^3 voxels, each holding signed Q3.12
// red, green and blue, and answers gradient queries: at (x,y,z) it returns red at
// x-1 minus red at x+1, green at y-1 minus green at y+1 and blue at z-1 minus blue
// at z+1, where any neighbor outside the configured size reads as zero. A transfer
// with req_mode low writes one voxel at linear address x + y*size_x +
// z*size_x*size_y and yields no result; a write outside the volume is dropped.
// A transfer with req_mode high yields exactly one result. Sizes of zero act as
// one, sizes above MAX_SIDE act as MAX_SIDE; change them only while the block is
// idle. Voxel memory is not cleared by reset: query only neighbors written before.
// The back end executes a write in state ST_X; a query steps through ST_X, ST_Y
// and ST_Z for the six neighbor reads through the voxel memory's two read ports
// (two neighbors a cycle), and no new command is taken until it has passed ST_Z.
// A two-entry command queue separates the address front end from the memory back
// end, and a two-entry result queue lets new items be accepted while results wait
// to be popped.
`default_nettype none

module voxel_central_difference_gradient
   import vcdg_pkg::*;
#(
   parameter int MAX_SIDE = 32
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_push,
   output logic                     req_full,
   input  logic                     req_mode,
   input  logic [COORD_W-1:0]       req_coord_x,
   input  logic [COORD_W-1:0]       req_coord_y,
   input  logic [COORD_W-1:0]       req_coord_z,
   input  logic signed [CHAN_W-1:0] req_red_in,
   input  logic signed [CHAN_W-1:0] req_green_in,
   input  logic signed [CHAN_W-1:0] req_blue_in,

   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [GRAD_W-1:0] rsp_grad_x,
   output logic signed [GRAD_W-1:0] rsp_grad_y,
   output logic signed [GRAD_W-1:0] rsp_grad_z,

   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [SIZE_W-1:0]        csr_wdata
);

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   geom_type geom;

   logic     cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type  cmd_wdata, cmd_rdata;

   logic     res_push, res_full;
   rsp_type  res_wdata, res_rdata;

   // Size registers; the plane size is a further register computed from them, so it is updated after them.
   vcdg_csr #(
      .MAX_SIDE (MAX_SIDE)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   // Front end: accept, classify neighbors, form the base address.
   vcdg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_mode     (req_mode),
      .req_coord_x  (req_coord_x),
      .req_coord_y  (req_coord_y),
      .req_coord_z  (req_coord_z),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .geom         (geom),
      .cmd_push     (cmd_push),
      .cmd_data     (cmd_wdata),
      .cmd_full     (cmd_full)
   );

   // Command queue: lets the front end run ahead of a busy back end.
   vcdg_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty)
   );

   // Back end: voxel memory and gradient sequencing.
   vcdg_back #(
      .MAX_SIDE (MAX_SIDE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_rdata),
      .rsp_full  (res_full),
      .rsp_push  (res_push),
      .rsp_data  (res_wdata)
   );

   // Result queue: hold finished gradients until the consumer pops them.
   vcdg_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_wdata),
      .full  (res_full),
      .pop   (rsp_pop),
      .rdata (res_rdata),
      .empty (rsp_empty)
   );

   assign rsp_grad_x = res_rdata.grad_x;
   assign rsp_grad_y = res_rdata.grad_y;
   assign rsp_grad_z = res_rdata.grad_z;

endmodule

`default_nettype wire

@@ hw/rtl/vcdg_checker.sv @@
// Port-level checker for the voxel gradient block and its bind statement.
`default_nettype none

module vcdg_checker
   import vcdg_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_push,
   input logic                     req_full,
   input logic                     rsp_empty,
   input logic                     rsp_pop,
   input logic signed [GRAD_W-1:0] rsp_grad_x,
   input logic signed [GRAD_W-1:0] rsp_grad_y,
   input logic signed [GRAD_W-1:0] rsp_grad_z
);

   // Reset leaves no result waiting and the input side open.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("block not empty and open after reset");

   // A waiting result that is not popped stays, unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_grad_x) && $stable(rsp_grad_y) && $stable(rsp_grad_z)))
      else $error("waiting result changed or vanished without a pop");

   // Results leave only through a pop.
   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_empty) |-> $past(rsp_pop))
      else $error("result queue emptied without a pop");

   // Input side fills only right after a transfer.
   a_full_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("full rose without a preceding transfer");

endmodule

bind voxel_central_difference_gradient vcdg_checker u_checker (.*);

`default_nettype wire
